### hdl/hqp_pkg.sv
`timescale 1ns / 1ps

package hqp_pkg;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
    } hqp_mac_ctl_t;

    localparam logic [1:0] FN_ROW   = 2'd0;
    localparam logic [1:0] FN_INV   = 2'd1;
    localparam logic [1:0] FN_START = 2'd2;
    localparam logic [1:0] FN_SOLVE = 2'd3;

    localparam logic [1:0] REG_MAX_SWEEPS   = 2'd0;
    localparam logic [1:0] REG_TOLERANCE    = 2'd1;
    localparam logic [1:0] REG_STALL_WINDOW = 2'd2;

    localparam logic [1:0] ST_LIMIT = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_STALL = 2'd2;

endpackage

### hdl/hqp_mac.sv
`timescale 1ns / 1ps

module hqp_mac
    import hqp_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  hqp_mac_ctl_t                  ctl,
    input  logic signed [31:0]            a,
    input  logic signed [31:0]            b,
    output logic signed [65-FRAC_BITS:0]  acc
);

    localparam int ACC_W = 66 - FRAC_BITS;

    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // product registered, then floor-shifted and accumulated
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= 64'(a) * 64'(b);
        end
        if (ctl.clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg >>> FRAC_BITS);
        end
    end

    assign acc = acc_reg;

endmodule

### hdl/hqp_div.sv
`timescale 1ns / 1ps

module hqp_div
    import hqp_pkg::*;
#(
    parameter int NUM_W = 48
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [30:0]      den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [30:0]      rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [31:0]      trial;
    logic [31:0]      diff;
    logic             ge;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[30:0] : trial[30:0];
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule

### hdl/hildreth_qp3_projection_core.sv
`timescale 1ns / 1ps

// channel   signals                                         direction
// request   start, busy, func, index, value_a..c,           in (busy out)
//           bound, divisor, count
// config    write_enable, write_index, write_data           in
// result    strobe, accel_x..z, row_number, multiplier,     out
//           sweeps_done, status, peak_violation,
//           active_count, last
//
// loads leave the core idle and may follow back to back
// per sweep, a solve is paced for each updated row by the shift-subtract
// divider of 32 + FRAC_BITS quotient bits and by the shared multiplier;
// a skipped row is only read, and the violation check visits each row
// then one strobed result per row, or one if there are no rows; strobe holds no back-pressure
// reset clears control and the multiplier valid bits and loads configuration defaults

module hildreth_qp3_projection_core
    import hqp_pkg::*;
#(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_WINDOW = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [5:0]         index,
    input  logic signed [31:0] value_a,
    input  logic signed [31:0] value_b,
    input  logic signed [31:0] value_c,
    input  logic signed [31:0] bound,
    input  logic [30:0]        divisor,
    input  logic [6:0]         count,
    input  logic               write_enable,
    input  logic [1:0]         write_index,
    input  logic [30:0]        write_data,
    output logic               strobe,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic signed [31:0] accel_z,
    output logic [5:0]         row_number,
    output logic [30:0]        multiplier,
    output logic [15:0]        sweeps_done,
    output logic [1:0]         status,
    output logic [30:0]        peak_violation,
    output logic [6:0]         active_count,
    output logic               last
);

    localparam int RA    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NW    = $clog2(MAX_ROWS + 1);
    localparam int RD    = MAX_WINDOW + 1;
    localparam int RAW   = $clog2(RD);
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int SH    = 32 + FRAC_BITS;
    localparam int ACC_W = 66 - FRAC_BITS;
    localparam int SW    = (SH + 2 > ACC_W + 1) ? SH + 2 : ACC_W + 1;
    localparam int STALL_FLOOR = ((1 << FRAC_BITS) + 500) / 1000;

    typedef struct packed {
        logic signed [31:0] n0;
        logic signed [31:0] n1;
        logic signed [31:0] n2;
        logic signed [31:0] b;
        logic [30:0]        d;
    } row_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SWEEP, S_U_RD, S_U_CHK, S_DOT, S_U_VIOL, S_U_DIV, S_U_CAND,
        S_U_T, S_U_SOL, S_C_BEGIN, S_C_RD, S_C_V, S_C_EVAL, S_STAG, S_E_RD, S_E_OUT
    } state_t;

    typedef enum logic [1:0] {
        DS_VIOL, DS_TDIR, DS_STEP
    } dot_sel_t;

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [31:0] r;
        if (v > $signed(SW'(32'h7fffffff)))
        begin
            r = 32'sh7fffffff;
        end
        else if (v < $signed({{(SW-31){1'b1}}, 31'b0}))
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = 32'(v);
        end
        return r;
    endfunction

    // storage
    row_t        row_mem [MAX_ROWS];
    row_t        row_q;
    logic [30:0] mult_mem [MAX_ROWS];
    logic [30:0] mult_q;
    logic [30:0] ring_mem [RD];
    logic [30:0] ring_q;

    state_t             state_reg;
    state_t             ret_reg;
    dot_sel_t           dot_sel_reg;
    logic [1:0]         ph_reg;
    logic [1:0]         i_reg;
    logic [RA-1:0]      k_reg;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      active_reg;
    logic [15:0]        limit_reg;
    logic [WW-1:0]      w_reg;
    logic [RAW-1:0]     wp_reg;
    logic [34:0]        floor_reg;
    logic [15:0]        sweeps_reg;
    logic [1:0]         status_reg;
    logic               final_reg;
    logic [30:0]        maxv_reg;
    logic [30:0]        big_reg;
    logic [30:0]        mult_cur_reg;
    logic [30:0]        cand_reg;
    logic signed [31:0] delta_reg;
    logic signed [31:0] t_reg;
    logic               neg_reg;
    logic [MAX_ROWS-1:0] mvalid_reg;
    logic signed [31:0] sol_reg [3];
    logic signed [31:0] start_reg [3];
    logic signed [31:0] inv_reg [9];
    logic [15:0]        max_sweeps_reg;
    logic [30:0]        tolerance_reg;
    logic [5:0]         stall_window_reg;

    logic               accept;
    logic               idx_ok;
    logic               row_we;
    logic               mult_we;
    logic               ring_we;
    logic [RAW:0]       ring_rd;
    logic [RAW-1:0]     ring_raddr;
    logic [1:0]         pj;
    logic [3:0]         inv_idx;
    logic signed [31:0] mac_a;
    logic signed [31:0] mac_b;
    hqp_mac_ctl_t       mac_ctl;
    logic signed [ACC_W-1:0] mac_acc;
    logic [1:0]         nterm;
    logic signed [31:0] dot_sat;
    logic signed [31:0] viol_c;
    logic [31:0]        viol_abs;
    logic               div_start;
    logic [SH-1:0]      div_q;
    logic               div_done;
    logic signed [SW-1:0] step_c;
    logic signed [SW-1:0] sum_c;
    logic [30:0]        cand_c;
    logic signed [31:0] delta_c;
    logic [30:0]        absd;
    logic [30:0]        mult_now;
    logic               k_last;
    logic [16:0]        s_next;
    logic               conv;
    logic signed [33:0] thr;
    logic               stag;

    assign busy    = state_reg != S_IDLE;
    assign accept  = start && (state_reg == S_IDLE);
    assign idx_ok  = 32'(index) < MAX_ROWS;
    assign row_we  = accept && (func == FN_ROW) && idx_ok;
    assign delta_c = $signed({1'b0, cand_reg}) - $signed({1'b0, mult_cur_reg});
    assign mult_we = (state_reg == S_U_CAND) && (delta_c != 0);
    assign ring_we = state_reg == S_C_EVAL;

    assign ring_rd = ({1'b0, wp_reg} >= (RAW+1)'(w_reg))
                   ? {1'b0, wp_reg} - (RAW+1)'(w_reg)
                   : {1'b0, wp_reg} + (RAW+1)'(RD) - (RAW+1)'(w_reg);
    assign ring_raddr = ring_rd[RAW-1:0];

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[RA'(index)] <= '{n0: value_a, n1: value_b, n2: value_c,
                                     b: bound, d: divisor};
        end
        row_q <= row_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mult_we)
        begin
            mult_mem[k_reg] <= cand_reg;
        end
        mult_q <= mult_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wp_reg] <= maxv_reg;
        end
        ring_q <= ring_mem[ring_raddr];
    end

    // shared multiply-accumulate operands
    assign pj      = (ph_reg == 2'd3) ? 2'd0 : ph_reg;
    assign inv_idx = 4'(i_reg) * 4'd3 + 4'(pj);
    assign nterm   = (dot_sel_reg == DS_STEP) ? 2'd1 : 2'd3;

    function automatic logic signed [31:0] row_n(input row_t r, input logic [1:0] j);
        logic signed [31:0] v;
        case (j)
            2'd0:    v = r.n0;
            2'd1:    v = r.n1;
            default: v = r.n2;
        endcase
        return v;
    endfunction

    always_comb
    begin
        mac_a = delta_reg;
        mac_b = t_reg;
        case (dot_sel_reg)
            DS_VIOL:
            begin
                mac_a = row_n(row_q, pj);
                mac_b = sol_reg[pj];
            end
            DS_TDIR:
            begin
                mac_a = inv_reg[inv_idx];
                mac_b = row_n(row_q, pj);
            end
            default:
            begin
                mac_a = delta_reg;
                mac_b = t_reg;
            end
        endcase
        mac_ctl.clr    = (state_reg == S_DOT) && (ph_reg == 2'd0);
        mac_ctl.mul_en = (state_reg == S_DOT) && (ph_reg < nterm);
        mac_ctl.acc_en = (state_reg == S_DOT) && (ph_reg != 2'd0);
    end

    hqp_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (mac_a),
        .b   (mac_b),
        .acc (mac_acc)
    );

    assign dot_sat  = sat32(SW'(mac_acc));
    assign viol_c   = sat32(SW'(row_q.b) - SW'(dot_sat));
    assign viol_abs = viol_c[31] ? 32'(-viol_c) : 32'(viol_c);
    assign div_start = state_reg == S_U_VIOL;

    hqp_div #(
        .NUM_W (SH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({viol_abs, {FRAC_BITS{1'b0}}}),
        .den   (row_q.d),
        .quo   (div_q),
        .done  (div_done)
    );

    assign step_c = neg_reg ? -$signed({{(SW-SH){1'b0}}, div_q})
                            : $signed({{(SW-SH){1'b0}}, div_q});
    assign sum_c  = $signed({{(SW-31){1'b0}}, mult_cur_reg}) + step_c;
    assign cand_c = (sum_c < 0) ? 31'd0
                  : (sum_c > $signed(SW'(32'h7fffffff))) ? 31'h7fffffff
                  : sum_c[30:0];

    assign absd     = delta_reg[31] ? 31'(-delta_reg) : delta_reg[30:0];
    assign mult_now = mvalid_reg[k_reg] ? mult_q : 31'd0;
    assign k_last   = (32'(k_reg) + 1) == 32'(n_reg);
    assign s_next   = {1'b0, sweeps_reg} + 17'd1;
    assign conv     = (maxv_reg <= tolerance_reg) && (big_reg <= tolerance_reg);
    assign thr      = $signed({3'b0, ring_q}) - $signed({23'b0, ring_q[30:20]})
                    - $signed({3'b0, tolerance_reg});
    assign stag     = ({4'b0, maxv_reg} > floor_reg)
                    && ($signed({3'b0, maxv_reg}) >= thr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ret_reg          <= S_IDLE;
            dot_sel_reg      <= DS_VIOL;
            ph_reg           <= '0;
            i_reg            <= '0;
            k_reg            <= '0;
            n_reg            <= '0;
            active_reg       <= '0;
            limit_reg        <= '0;
            w_reg            <= '0;
            wp_reg           <= '0;
            floor_reg        <= '0;
            sweeps_reg       <= '0;
            status_reg       <= ST_LIMIT;
            final_reg        <= 1'b0;
            maxv_reg         <= '0;
            big_reg          <= '0;
            mult_cur_reg     <= '0;
            cand_reg         <= '0;
            delta_reg        <= '0;
            t_reg            <= '0;
            neg_reg          <= 1'b0;
            mvalid_reg       <= '0;
            sol_reg          <= '{default: '0};
            start_reg        <= '{default: '0};
            inv_reg          <= '{default: '0};
            max_sweeps_reg   <= 16'd100;
            tolerance_reg    <= 31'd66;
            stall_window_reg <= 6'd10;
            strobe           <= 1'b0;
            accel_x          <= '0;
            accel_y          <= '0;
            accel_z          <= '0;
            row_number       <= '0;
            multiplier       <= '0;
            sweeps_done      <= '0;
            status           <= ST_LIMIT;
            peak_violation   <= '0;
            active_count     <= '0;
            last             <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            if (write_enable)
            begin
                unique case (write_index)
                    REG_MAX_SWEEPS:   max_sweeps_reg   <= write_data[15:0];
                    REG_TOLERANCE:    tolerance_reg    <= write_data;
                    REG_STALL_WINDOW: stall_window_reg <= write_data[5:0];
                    default:          ;
                endcase
            end
            if (mult_we)
            begin
                mvalid_reg[k_reg] <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (func)
                            FN_ROW: ;
                            FN_INV:
                            begin
                                if (index <= 6'd2)
                                begin
                                    inv_reg[4'(index) * 4'd3]        <= value_a;
                                    inv_reg[4'(index) * 4'd3 + 4'd1] <= value_b;
                                    inv_reg[4'(index) * 4'd3 + 4'd2] <= value_c;
                                end
                            end
                            FN_START:
                            begin
                                start_reg[0] <= value_a;
                                start_reg[1] <= value_b;
                                start_reg[2] <= value_c;
                            end
                            default:
                            begin
                                sol_reg    <= start_reg;
                                mvalid_reg <= '0;
                                sweeps_reg <= '0;
                                wp_reg     <= '0;
                                final_reg  <= 1'b0;
                                k_reg      <= '0;
                                if (32'(count) > MAX_ROWS)
                                begin
                                    n_reg <= NW'(MAX_ROWS);
                                end
                                else
                                begin
                                    n_reg <= NW'(count);
                                end
                                limit_reg <= (max_sweeps_reg == 16'd0) ? 16'd1
                                                                       : max_sweeps_reg;
                                if (stall_window_reg == 6'd0)
                                begin
                                    w_reg <= WW'(1);
                                end
                                else if (32'(stall_window_reg) > MAX_WINDOW)
                                begin
                                    w_reg <= WW'(MAX_WINDOW);
                                end
                                else
                                begin
                                    w_reg <= WW'(stall_window_reg);
                                end
                                if ({tolerance_reg, 3'b0} + {3'b0, tolerance_reg, 1'b0}
                                    < 35'(STALL_FLOOR))
                                begin
                                    floor_reg <= 35'(STALL_FLOOR);
                                end
                                else
                                begin
                                    floor_reg <= {1'b0, tolerance_reg, 3'b0}
                                               + {3'b0, tolerance_reg, 1'b0};
                                end
                                state_reg <= S_SWEEP;
                            end
                        endcase
                    end
                end

                S_SWEEP:
                begin
                    k_reg   <= '0;
                    big_reg <= '0;
                    state_reg <= (n_reg == '0) ? S_C_BEGIN : S_U_RD;
                end

                S_U_RD:
                begin
                    state_reg <= S_U_CHK;
                end

                S_U_CHK:
                begin
                    mult_cur_reg <= mult_now;
                    if (row_q.d == 31'd0)
                    begin
                        if (k_last)
                        begin
                            state_reg <= S_C_BEGIN;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_U_RD;
                        end
                    end
                    else
                    begin
                        dot_sel_reg <= DS_VIOL;
                        ph_reg      <= '0;
                        ret_reg     <= S_U_VIOL;
                        state_reg   <= S_DOT;
                    end
                end

                S_DOT:
                begin
                    if (ph_reg == nterm)
                    begin
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 1'b1;
                    end
                end

                S_U_VIOL:
                begin
                    neg_reg   <= viol_c[31];
                    state_reg <= S_U_DIV;
                end

                S_U_DIV:
                begin
                    if (div_done)
                    begin
                        cand_reg  <= cand_c;
                        state_reg <= S_U_CAND;
                    end
                end

                S_U_CAND:
                begin
                    if (delta_c == 0)
                    begin
                        if (k_last)
                        begin
                            state_reg <= S_C_BEGIN;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_U_RD;
                        end
                    end
                    else
                    begin
                        delta_reg   <= delta_c;
                        i_reg       <= '0;
                        dot_sel_reg <= DS_TDIR;
                        ph_reg      <= '0;
                        ret_reg     <= S_U_T;
                        state_reg   <= S_DOT;
                    end
                end

                S_U_T:
                begin
                    t_reg <= dot_sat;
                    if ((i_reg == 2'd0) && (absd > big_reg))
                    begin
                        big_reg <= absd;
                    end
                    dot_sel_reg <= DS_STEP;
                    ph_reg      <= '0;
                    ret_reg     <= S_U_SOL;
                    state_reg   <= S_DOT;
                end

                S_U_SOL:
                begin
                    sol_reg[i_reg] <= sat32(SW'(sol_reg[i_reg]) + SW'(mac_acc));
                    if (i_reg == 2'd2)
                    begin
                        if (k_last)
                        begin
                            state_reg <= S_C_BEGIN;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_U_RD;
                        end
                    end
                    else
                    begin
                        i_reg       <= i_reg + 1'b1;
                        dot_sel_reg <= DS_TDIR;
                        ph_reg      <= '0;
                        ret_reg     <= S_U_T;
                        state_reg   <= S_DOT;
                    end
                end

                S_C_BEGIN:
                begin
                    k_reg      <= '0;
                    maxv_reg   <= '0;
                    active_reg <= '0;
                    if (n_reg != '0)
                    begin
                        state_reg <= S_C_RD;
                    end
                    else
                    begin
                        state_reg <= final_reg ? S_E_RD : S_C_EVAL;
                    end
                end

                S_C_RD:
                begin
                    dot_sel_reg <= DS_VIOL;
                    ph_reg      <= '0;
                    ret_reg     <= S_C_V;
                    state_reg   <= S_DOT;
                end

                S_C_V:
                begin
                    if (viol_c > $signed({1'b0, maxv_reg}))
                    begin
                        maxv_reg <= viol_c[30:0];
                    end
                    if (final_reg && (mult_now > tolerance_reg))
                    begin
                        active_reg <= active_reg + 1'b1;
                    end
                    if (k_last)
                    begin
                        if (final_reg)
                        begin
                            k_reg     <= '0;
                            state_reg <= S_E_RD;
                        end
                        else
                        begin
                            state_reg <= S_C_EVAL;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_C_RD;
                    end
                end

                S_C_EVAL:
                begin
                    sweeps_reg <= s_next[15:0];
                    if (conv)
                    begin
                        status_reg <= ST_CONV;
                        final_reg  <= 1'b1;
                        state_reg  <= S_C_BEGIN;
                    end
                    else if (s_next > 17'(w_reg))
                    begin
                        state_reg <= S_STAG;
                    end
                    else if (s_next[15:0] == limit_reg)
                    begin
                        status_reg <= ST_LIMIT;
                        final_reg  <= 1'b1;
                        state_reg  <= S_C_BEGIN;
                    end
                    else
                    begin
                        wp_reg    <= (wp_reg == RAW'(RD - 1)) ? '0 : wp_reg + 1'b1;
                        state_reg <= S_SWEEP;
                    end
                end

                S_STAG:
                begin
                    if (stag)
                    begin
                        status_reg <= ST_STALL;
                        final_reg  <= 1'b1;
                        state_reg  <= S_C_BEGIN;
                    end
                    else if (sweeps_reg == limit_reg)
                    begin
                        status_reg <= ST_LIMIT;
                        final_reg  <= 1'b1;
                        state_reg  <= S_C_BEGIN;
                    end
                    else
                    begin
                        wp_reg    <= (wp_reg == RAW'(RD - 1)) ? '0 : wp_reg + 1'b1;
                        state_reg <= S_SWEEP;
                    end
                end

                S_E_RD:
                begin
                    state_reg <= S_E_OUT;
                end

                S_E_OUT:
                begin
                    strobe         <= 1'b1;
                    accel_x        <= sol_reg[0];
                    accel_y        <= sol_reg[1];
                    accel_z        <= sol_reg[2];
                    row_number     <= 6'(k_reg);
                    multiplier     <= (n_reg == '0) ? 31'd0 : mult_now;
                    sweeps_done    <= sweeps_reg;
                    status         <= status_reg;
                    peak_violation <= maxv_reg;
                    active_count   <= 7'(active_reg);
                    if ((n_reg == '0) || k_last)
                    begin
                        last      <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        last      <= 1'b0;
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_E_RD;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
